// File: hdl/urc_pkg.sv
package urc_pkg;

  // Field widths of the configuration and result items
  localparam int unsigned RepeatW    = 20;
  localparam int unsigned TrigW      = 10;
  localparam int unsigned DistW      = 14;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = RepeatW;

  // Default echo counter width
  localparam int unsigned EchoCountBitsDef = 16;

  // Reset values of the configuration registers
  localparam logic [RepeatW-1:0] RepeatReset = 20'd60000;
  localparam logic [TrigW-1:0]   TrigReset   = 10'd10;
  localparam logic [DistW-1:0]   ThreshReset = 14'd400;

  // Distance shown before the first measurement, above the default threshold
  localparam logic [DistW-1:0]   DistReset   = 14'd410;

  // Distance conversion: mm = count * 17 / 100, done as (count * DistMul) >> DistShift.
  // Counts from DistClamp upward already give the saturated distance, so the
  // multiplier input is clamped to a 17-bit value.
  localparam int unsigned        DistInW   = 17;
  localparam logic [31:0]        DistClamp = 32'd96376;
  localparam int unsigned        DistShift = 24;
  localparam int unsigned        DistMulW  = 22;
  localparam logic [DistMulW-1:0] DistMul  = 22'd2852127;
  localparam int unsigned        DistProdW = DistInW + DistMulW;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_INTERVAL  = 2'd1,
    CFG_TRIG_W    = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_e;

  // Current configuration
  typedef struct packed {
    logic               enable;
    logic [RepeatW-1:0] interval;
    logic [TrigW-1:0]   trig_width;
    logic [DistW-1:0]   threshold;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic             trigger;
    logic [DistW-1:0] distance;
    logic             obstacle;
    logic             fresh;
  } res_t;

endpackage

// File: hdl/urc_cfg_regs.sv
module urc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [urc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [urc_pkg::CfgDataW-1:0] cfg_data_i,
  output urc_pkg::cfg_t                cfg_o
);
  import urc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE:    cfg_d.enable     = cfg_data_i[0];
        CFG_INTERVAL:  cfg_d.interval   = cfg_data_i[RepeatW-1:0];
        CFG_TRIG_W:    cfg_d.trig_width = cfg_data_i[TrigW-1:0];
        CFG_THRESHOLD: cfg_d.threshold  = cfg_data_i[DistW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.interval   <= RepeatReset;
      cfg_q.trig_width <= TrigReset;
      cfg_q.threshold  <= ThreshReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/urc_dist.sv
module urc_dist #(
  parameter int unsigned EchoCountBits = urc_pkg::EchoCountBitsDef
) (
  input  logic [EchoCountBits-1:0]   count_i,
  output logic [urc_pkg::DistW-1:0]  dist_o
);
  import urc_pkg::*;

  logic [31:0]           count_ext;
  logic [DistInW-1:0]    count_clamped;
  logic [DistProdW-1:0]  prod;

  // Clamp to the count where the distance saturates
  assign count_ext     = 32'(count_i);
  assign count_clamped = (count_ext > DistClamp) ? DistClamp[DistInW-1:0]
                                                 : count_ext[DistInW-1:0];

  // Multiply by the scaled reciprocal and drop the fraction bits
  assign prod   = DistProdW'(count_clamped) * DistProdW'(DistMul);
  assign dist_o = prod[DistShift +: DistW];

endmodule

// File: hdl/urc_tick.sv
module urc_tick #(
  parameter int unsigned EchoCountBits = urc_pkg::EchoCountBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          echo_i,
  input  urc_pkg::cfg_t cfg_i,
  output urc_pkg::res_t res_o
);
  import urc_pkg::*;

  logic [RepeatW-1:0]       rep_q, rep_d;
  logic [TrigW-1:0]         trig_cnt_q, trig_cnt_d;
  logic                     trig_q, trig_d;
  logic [EchoCountBits-1:0] echo_cnt_q, echo_cnt_d;
  logic                     echo_prev_q, echo_prev_d;
  logic                     seen_q, seen_d;
  logic [DistW-1:0]         dist_q, dist_d;
  logic                     en_prev_q, en_prev_d;

  logic [RepeatW-1:0]       rep_inc;
  logic [EchoCountBits-1:0] echo_inc;
  logic [DistW-1:0]         dist_new;
  logic                     fresh;

  // Saturating increments
  assign rep_inc  = (rep_q == '1) ? rep_q : RepeatW'(rep_q + 1'b1);
  assign echo_inc = (echo_cnt_q == '1) ? echo_cnt_q : EchoCountBits'(echo_cnt_q + 1'b1);

  urc_dist #(
    .EchoCountBits(EchoCountBits)
  ) u_dist (
    .count_i(echo_inc),
    .dist_o (dist_new)
  );

  // Advance the tick state
  always_comb begin
    rep_d       = rep_q;
    trig_cnt_d  = trig_cnt_q;
    trig_d      = trig_q;
    echo_cnt_d  = echo_cnt_q;
    seen_d      = seen_q;
    dist_d      = dist_q;
    fresh       = 1'b0;

    // time out a running pulse
    if (trig_q) begin
      if (trig_cnt_q != '1) begin
        trig_cnt_d = TrigW'(trig_cnt_q + 1'b1);
      end
      if (trig_cnt_d > cfg_i.trig_width) begin
        trig_d = 1'b0;
      end
    end

    if (cfg_i.enable) begin
      // fire on enable rise or when the repeat count passes the interval
      if (!en_prev_q) begin
        rep_d      = '0;
        trig_d     = 1'b1;
        trig_cnt_d = '0;
      end else if (rep_inc > cfg_i.interval) begin
        rep_d      = '0;
        trig_d     = 1'b1;
        trig_cnt_d = '0;
      end else begin
        rep_d = rep_inc;
      end

      // time the echo high phase
      if (echo_i && !echo_prev_q) begin
        echo_cnt_d = '0;
        seen_d     = 1'b1;
      end else if (seen_q && (echo_i || echo_prev_q)) begin
        echo_cnt_d = echo_inc;
        if (!echo_i) begin
          dist_d = dist_new;
          seen_d = 1'b0;
          fresh  = 1'b1;
        end
      end
    end else begin
      rep_d  = '0;
      seen_d = 1'b0;
    end

    en_prev_d   = cfg_i.enable;
    echo_prev_d = echo_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q       <= '0;
      trig_cnt_q  <= '0;
      trig_q      <= 1'b0;
      echo_cnt_q  <= '0;
      echo_prev_q <= 1'b0;
      seen_q      <= 1'b0;
      dist_q      <= DistReset;
      en_prev_q   <= 1'b0;
    end else if (step_i) begin
      rep_q       <= rep_d;
      trig_cnt_q  <= trig_cnt_d;
      trig_q      <= trig_d;
      echo_cnt_q  <= echo_cnt_d;
      echo_prev_q <= echo_prev_d;
      seen_q      <= seen_d;
      dist_q      <= dist_d;
      en_prev_q   <= en_prev_d;
    end
  end

  // Result of this tick, taken from the next state
  always_comb begin
    res_o.trigger  = trig_d;
    res_o.distance = dist_d;
    res_o.obstacle = (dist_d < cfg_i.threshold);
    res_o.fresh    = fresh;
  end

endmodule

// File: hdl/ultrasonic_ranger_controller_top.sv
// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_stall_o   | echo_level_i
// output  | out       | out_valid_o / out_stall_i | trigger_out_o, distance_mm_o,
//         |           |                           | obstacle_o, new_measurement_o
// config  | in        | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One tick per clock while the output is not stalled: an accepted tick sits in the input
// register, is processed by the counter and distance logic at the first rising edge at
// which the output register is free, and lands in the output register. The distance
// multiplier sets the longest path. Reset is asynchronous, active low, and loads the
// default configuration. A stalled output holds its transaction; the input stalls only
// when both registers are full and the output is stalled.
module ultrasonic_ranger_controller_top #(
  parameter int unsigned ECHO_COUNT_BITS = urc_pkg::EchoCountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [urc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [urc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         echo_level_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         trigger_out_o,
  output logic [urc_pkg::DistW-1:0]    distance_mm_o,
  output logic                         obstacle_o,
  output logic                         new_measurement_o
);
  import urc_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_q;

  logic in_valid_q, in_valid_d;
  logic echo_q;
  logic out_valid_q, out_valid_d;
  logic out_free, step, in_take;

  urc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake between the two registers
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted echo sample
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      echo_q <= echo_level_i;
    end
  end

  urc_tick #(
    .EchoCountBits(ECHO_COUNT_BITS)
  ) u_tick (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .echo_i(echo_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign trigger_out_o     = out_q.trigger;
  assign distance_mm_o     = out_q.distance;
  assign obstacle_o        = out_q.obstacle;
  assign new_measurement_o = out_q.fresh;

endmodule

// File: hdl/urc_checker.sv
module urc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [urc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [urc_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         echo_level_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         trigger_out_o,
  input logic [urc_pkg::DistW-1:0]    distance_mm_o,
  input logic                         obstacle_o,
  input logic                         new_measurement_o
);
  import urc_pkg::*;

  logic             en_seen_q;
  logic             meas_seen_q;
  logic             out_seen_q;
  logic [DistW-1:0] last_dist_q;
  logic             out_take;

  assign out_take = out_valid_o && !out_stall_i;

  // Track enable writes and the last delivered distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_seen_q   <= 1'b0;
      meas_seen_q <= 1'b0;
      out_seen_q  <= 1'b0;
      last_dist_q <= DistReset;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_ENABLE) && cfg_data_i[0]) begin
        en_seen_q <= 1'b1;
      end
      if (out_take) begin
        out_seen_q  <= 1'b1;
        last_dist_q <= distance_mm_o;
        if (new_measurement_o) begin
          meas_seen_q <= 1'b1;
        end
      end
    end
  end

  // Stalled input transaction keeps its valid and its echo sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(echo_level_i))
    else $error("input transaction changed while stalled");

  // Stalled output transaction keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // Distance only moves with a new measurement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_seen_q && !new_measurement_o |-> distance_mm_o == last_dist_q)
    else $error("distance changed without a new measurement");

  // Before any measurement the reset distance is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !meas_seen_q && !new_measurement_o |-> distance_mm_o == DistReset)
    else $error("distance differs from its reset value before any measurement");

  // No trigger and no measurement before ranging was ever enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !en_seen_q |-> !trigger_out_o && !new_measurement_o)
    else $error("activity before ranging was enabled");

endmodule

bind ultrasonic_ranger_controller_top urc_checker u_urc_checker (.*);

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import urc_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned EchoBits   = EchoCountBitsDef;
  localparam int unsigned RandTicks  = 850;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = CFG_ENABLE;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                echo_level_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                trigger_out_o;
  logic [DistW-1:0]    distance_mm_o;
  logic                obstacle_o;
  logic                new_measurement_o;

  ultrasonic_ranger_controller_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .echo_level_i,
    .out_valid_o,
    .out_stall_i,
    .trigger_out_o,
    .distance_mm_o,
    .obstacle_o,
    .new_measurement_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Register copy kept alongside the block
  logic                en_reg        = 1'b0;
  logic [RepeatW-1:0]  interval_reg  = RepeatReset;
  logic [TrigW-1:0]    width_reg     = TrigReset;
  logic [DistW-1:0]    threshold_reg = ThreshReset;

  // Predicted ranging state
  logic [RepeatW-1:0]  repeat_cnt = '0;
  logic [TrigW-1:0]    trig_cnt   = '0;
  logic                trig_level = 1'b0;
  logic [EchoBits-1:0] echo_cnt   = '0;
  logic                echo_prev  = 1'b0;
  logic                rise_seen  = 1'b0;
  logic [DistW-1:0]    last_dist  = DistReset;
  logic                en_prev    = 1'b0;

  res_t        expected_readings[$];
  int unsigned error_count = 0;
  int unsigned ticks_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  bit          idle_on     = 1'b1;

  // Advance the predicted state by one microsecond tick
  function automatic res_t ranger_tick(input logic echo);
    res_t            r;
    logic            fresh;
    longint unsigned prod;
    fresh = 1'b0;
    if (trig_level) begin
      if (trig_cnt != {TrigW{1'b1}}) trig_cnt++;
      if (trig_cnt > width_reg) trig_level = 1'b0;
    end
    if (en_reg) begin
      if (!en_prev) begin
        repeat_cnt = '0;
        trig_level = 1'b1;
        trig_cnt   = '0;
      end else begin
        if (repeat_cnt != {RepeatW{1'b1}}) repeat_cnt++;
        if (repeat_cnt > interval_reg) begin
          repeat_cnt = '0;
          trig_level = 1'b1;
          trig_cnt   = '0;
        end
      end
      // Time the high phase of the echo pin
      if (echo && !echo_prev) begin
        echo_cnt  = '0;
        rise_seen = 1'b1;
      end else if (rise_seen && (echo || echo_prev)) begin
        if (echo_cnt != {EchoBits{1'b1}}) echo_cnt++;
        if (!echo) begin
          prod      = echo_cnt;
          prod      = prod * 17 / 100;
          last_dist = (prod > {DistW{1'b1}}) ? {DistW{1'b1}} : prod[DistW-1:0];
          rise_seen = 1'b0;
          fresh     = 1'b1;
        end
      end
    end else begin
      repeat_cnt = '0;
      rise_seen  = 1'b0;
    end
    en_prev        = en_reg;
    echo_prev      = echo;
    r.trigger      = trig_level;
    r.distance     = last_dist;
    r.obstacle     = (last_dist < threshold_reg);
    r.fresh        = fresh;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Compare one result transaction with the oldest prediction
  task automatic check_reading();
    res_t want;
    if (expected_readings.size() == 0) begin
      $error("result with no tick pending: trigger %0d distance %0d",
             trigger_out_o, distance_mm_o);
      error_count++;
      return;
    end
    want = expected_readings.pop_front();
    if (trigger_out_o !== want.trigger) begin
      $error("trigger_out: expected %0d, got %0d", want.trigger, trigger_out_o);
      error_count++;
    end
    if (distance_mm_o !== want.distance) begin
      $error("distance_mm: expected %0d, got %0d", want.distance, distance_mm_o);
      error_count++;
    end
    if (obstacle_o !== want.obstacle) begin
      $error("obstacle: expected %0d, got %0d", want.obstacle, obstacle_o);
      error_count++;
    end
    if (new_measurement_o !== want.fresh) begin
      $error("new_measurement: expected %0d, got %0d", want.fresh, new_measurement_o);
      error_count++;
    end
  endtask

  // Check each result transaction ahead of the edge that takes it
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_reading();
    end
  end

  // Pick the next output stall
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** ultrasonic_ranger_controller_top: FAILED **");
      $finish;
    end
  end

  // Offer one echo sample and hold it until the block takes it
  task automatic send_echo(input logic level);
    int unsigned gap;
    logic        stalled;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    echo_level_i <= level;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    expected_readings.push_back(ranger_tick(level));
    ticks_sent++;
  endtask

  task automatic send_run(input logic level, input int unsigned len);
    repeat (len) send_echo(level);
  endtask

  // Drop valid and wait until every tick has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:    en_reg        = value[0];
      CFG_INTERVAL:  interval_reg  = value[RepeatW-1:0];
      CFG_TRIG_W:    width_reg     = value[TrigW-1:0];
      CFG_THRESHOLD: threshold_reg = value[DistW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // Disabled after reset: echo pulses are ignored, distance keeps its reset value
  task automatic test_reset_state();
    send_echo(1'b1);
    send_echo(1'b1);
    send_echo(1'b0);
    settle();
  endtask

  // Enable rise fires a one-tick pulse, repeats follow the short interval
  task automatic test_trigger_timing();
    write_reg(CFG_INTERVAL, CfgDataW'(2));
    write_reg(CFG_TRIG_W, CfgDataW'(0));
    write_reg(CFG_ENABLE, CfgDataW'(1));
    send_run(1'b0, 6);
    settle();
  endtask

  // Fall without a rise, then short pulses at both threshold extremes, the last the shortest
  task automatic test_echo_edges();
    write_reg(CFG_ENABLE, CfgDataW'(0));
    send_echo(1'b1);
    settle();
    write_reg(CFG_ENABLE, CfgDataW'(1));
    write_reg(CFG_THRESHOLD, CfgDataW'({DistW{1'b1}}));
    send_echo(1'b0);
    send_run(1'b1, 3);
    send_echo(1'b0);
    settle();
    write_reg(CFG_THRESHOLD, CfgDataW'(0));
    send_echo(1'b1);
    send_echo(1'b0);
    settle();
  endtask

  // A pulse restarts on every tick
  task automatic test_interval_zero();
    write_reg(CFG_INTERVAL, CfgDataW'(0));
    send_run(1'b0, 3);
    settle();
  endtask

  // The pulse times out and the echo fall is ignored after disable
  task automatic test_disable_mid_pulse();
    write_reg(CFG_ENABLE, CfgDataW'(0));
    write_reg(CFG_INTERVAL, CfgDataW'(1000));
    write_reg(CFG_TRIG_W, CfgDataW'(1));
    write_reg(CFG_ENABLE, CfgDataW'(1));
    send_run(1'b1, 2);
    settle();
    write_reg(CFG_ENABLE, CfgDataW'(0));
    send_echo(1'b1);
    send_run(1'b0, 2);
    settle();
  endtask

  // Hold the output off long enough for the block to stall its input
  task automatic test_output_backpressure();
    write_reg(CFG_INTERVAL, CfgDataW'(5));
    write_reg(CFG_TRIG_W, CfgDataW'(2));
    write_reg(CFG_ENABLE, CfgDataW'(1));
    idle_on = 1'b0;
    @(posedge clk_i);
    hold_left = 200;
    send_run(1'b0, 3);
    send_run(1'b1, 12);
    send_run(1'b0, 9);
    idle_on = 1'b1;
    settle();
  endtask

  // Random settings, then echo pulse trains with some noise mixed in
  task automatic test_random_ranging();
    int unsigned start_ticks;
    int unsigned phase_end;
    int unsigned roll;
    logic [CfgDataW-1:0] value;
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < RandTicks) begin
      settle();
      idle_on = ($urandom_range(0, 99) < 75);
      roll = $urandom_range(0, 99);
      if (roll < 70)      value = $urandom_range(0, 60);
      else if (roll < 92) value = $urandom_range(61, 400);
      else if (roll < 96) value = 1000000;
      else                value = $urandom_range(0, 20'hFFFFF);
      write_reg(CFG_INTERVAL, value);
      roll = $urandom_range(0, 99);
      if (roll < 85)      value = $urandom_range(0, 20);
      else if (roll < 93) value = 1023;
      else                value = $urandom_range(0, 1023);
      write_reg(CFG_TRIG_W, value);
      roll = $urandom_range(0, 99);
      if (roll < 75)      value = $urandom_range(0, 60);
      else if (roll < 90) value = $urandom_range(61, 140);
      else                value = $urandom_range(0, 16383);
      write_reg(CFG_THRESHOLD, value);
      write_reg(CFG_ENABLE, CfgDataW'($urandom_range(0, 99) < 85));
      phase_end = ticks_sent + $urandom_range(30, 120);
      while (ticks_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          send_run(1'b0, $urandom_range(0, 12));
          roll = $urandom_range(0, 99);
          if (roll < 70)      send_run(1'b1, $urandom_range(1, 20));
          else if (roll < 95) send_run(1'b1, $urandom_range(21, 300));
          else                send_run(1'b1, $urandom_range(301, 800));
          send_echo(1'b0);
        end else begin
          repeat ($urandom_range(1, 6)) send_echo(1'($urandom_range(0, 1)));
        end
      end
    end
    idle_on = 1'b1;
    settle();
  endtask

  // Widest pulse setting with repeats out of reach: the trigger stays high
  task automatic test_long_pulse();
    write_reg(CFG_ENABLE, CfgDataW'(0));
    write_reg(CFG_INTERVAL, CfgDataW'(20'hFFFFF));
    write_reg(CFG_TRIG_W, CfgDataW'(1023));
    write_reg(CFG_THRESHOLD, CfgDataW'(11140));
    write_reg(CFG_ENABLE, CfgDataW'(1));
    send_echo(1'b0);
    send_run(1'b1, 150);
    send_run(1'b0, 3);
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_trigger_timing();
    test_echo_edges();
    test_interval_zero();
    test_disable_mid_pulse();
    test_output_backpressure();
    test_random_ranging();
    test_long_pulse();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** ultrasonic_ranger_controller_top: PASSED **");
    end else begin
      $display("** ultrasonic_ranger_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
